[hw/rtl/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and reset values for the throttle controller status unit.
// ----------------------------------------------------------------------------
package tcs_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_BAND_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_BAND_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_SCALE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCK_ENABLE    = 2'd3;

   localparam logic [SAMPLE_BITS-1:0] DEAD_BAND_LOW_RESET  = SAMPLE_BITS'(480);
   localparam logic [SAMPLE_BITS-1:0] DEAD_BAND_HIGH_RESET = SAMPLE_BITS'(540);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RESET     = SAMPLE_BITS'(1023);

   // mains switch positions
   localparam logic [1:0] MAINS_POS_UNKNOWN = 2'd0;
   localparam logic [1:0] MAINS_POS_OFF     = 2'd1;
   localparam logic [1:0] MAINS_POS_ON      = 2'd2;
   localparam logic [1:0] MAINS_POS_PLUS    = 2'd3;

   // direction switch positions
   localparam logic [1:0] DIR_POS_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_POS_MIDDLE  = 2'd1;
   localparam logic [1:0] DIR_POS_FWD     = 2'd2;
   localparam logic [1:0] DIR_POS_REV     = 2'd3;

   // controller status codes
   localparam logic [2:0] ST_LOCKED     = 3'd0;
   localparam logic [2:0] ST_OFF        = 3'd1;
   localparam logic [2:0] ST_NOT_NULLED = 3'd2;
   localparam logic [2:0] ST_STANDBY    = 3'd3;
   localparam logic [2:0] ST_READY      = 3'd4;
   localparam logic [2:0] ST_MOVING     = 3'd5;
   localparam logic [2:0] ST_SETUP      = 3'd6;

   typedef struct packed {
      logic [1:0]             mains_position;
      logic [1:0]             direction_position;
      logic [SAMPLE_BITS-1:0] throttle_sample;
      logic                   horn_pushed;
      logic                   foreign_drive_seen;
      logic                   status_received;
      logic                   status_moving;
   } req_type;

   typedef struct packed {
      logic [2:0]             controller_status;
      logic [SAMPLE_BITS-1:0] drive_value;
      logic [SAMPLE_BITS-1:0] brake_value;
      logic                   is_active;
      logic                   mains_held;
      logic                   aux_on;
      logic                   reverse_selected;
      logic                   drive_enabled;
   } rsp_type;

endpackage

[hw/rtl/throttle_controller_status_unit.sv]
// ----------------------------------------------------------------------------
// throttle_controller_status_unit
// Switch flag update, dead band throttle mapping through a shared multiply and
// shift-subtract divider, and the seven-state controller sequencer.
// ----------------------------------------------------------------------------
// flow: an input beat is registered, then passes S_MUL, the one-bit-per-cycle
//   divider loop in S_DIV and S_DONE before the result is registered; S_DIV is
//   skipped when the throttle maps to neither drive nor brake. A new beat is
//   taken only in S_IDLE, so not while one is in flight, but it is taken while
//   a finished result waits on the output
// reset: synchronous, clears the sequencer, flags and output valid, loads the
//   register defaults, status reads off
module throttle_controller_status_unit
   import tcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]    csr_wdata
);

   localparam int N = SAMPLE_BITS;
   localparam int CNT_W = $clog2(2 * N);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_DRIVE = 2'd1;
   localparam logic [1:0] MODE_BRAKE = 2'd2;

   // config registers
   logic [N-1:0] low_ff, high_ff, fs_ff;
   logic         lock_ff;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       mode_ff, mode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic             active_ff, active_in;
   logic             nulled_ff, nulled_in;
   logic             mains_ff, mains_in;
   logic             aux_ff, aux_in;
   logic             reverse_ff, reverse_in;
   logic             drive_on_ff, drive_on_in;
   logic             moving_ff, moving_in;

   // payload
   req_type        item_ff, item_in;
   logic [N-1:0]   num_ff, num_in;
   logic [N-1:0]   den_ff, den_in;
   logic [2*N-1:0] qd_ff, qd_in;
   logic [N-1:0]   rem_ff, rem_in;
   rsp_type        rsp_ff, rsp_in;

   logic           accept;
   logic           done_go;
   logic [N:0]     trial;
   logic [N:0]     diff;
   logic           fits;
   logic [N-1:0]   q_sat;
   logic [N-1:0]   drive_res;
   logic [N-1:0]   brake_res;
   logic           can_act;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign done_go = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // shift-subtract step
   assign trial = {rem_ff, qd_ff[2*N-1]};
   assign diff = trial - {1'b0, den_ff};
   assign fits = (trial >= {1'b0, den_ff});

   assign q_sat = (qd_ff > {{N{1'b0}}, fs_ff}) ? fs_ff : qd_ff[N-1:0];
   assign drive_res = (mode_ff == MODE_DRIVE) ? q_sat : '0;
   assign brake_res = (mode_ff == MODE_BRAKE) ? q_sat : '0;
   assign can_act = !lock_ff || (!item_ff.foreign_drive_seen && item_ff.mains_position[1]);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      active_in = active_ff;
      nulled_in = nulled_ff;
      mains_in = mains_ff;
      aux_in = aux_ff;
      reverse_in = reverse_ff;
      drive_on_in = drive_on_ff;
      moving_in = moving_ff;
      item_in = item_ff;
      num_in = num_ff;
      den_in = den_ff;
      qd_in = qd_ff;
      rem_in = rem_ff;
      rsp_in = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.status_received) begin
                  moving_in = req_data.status_moving;
               end
               case (req_data.mains_position)
                  MAINS_POS_OFF: begin
                     mains_in = 1'b0;
                     aux_in = 1'b0;
                  end
                  MAINS_POS_ON: begin
                     mains_in = 1'b1;
                     aux_in = 1'b0;
                  end
                  MAINS_POS_PLUS: begin
                     mains_in = 1'b1;
                     aux_in = 1'b1;
                  end
                  default: ;
               endcase
               case (req_data.direction_position)
                  DIR_POS_REV: begin
                     reverse_in = 1'b1;
                     drive_on_in = 1'b1;
                  end
                  DIR_POS_MIDDLE: drive_on_in = 1'b0;
                  DIR_POS_FWD: begin
                     reverse_in = 1'b0;
                     drive_on_in = 1'b1;
                  end
                  default: ;
               endcase
               mode_in = MODE_NONE;
               num_in = '0;
               den_in = '0;
               if (mains_in) begin
                  if (req_data.throttle_sample < low_ff) begin
                     mode_in = MODE_BRAKE;
                     num_in = low_ff - req_data.throttle_sample;
                     den_in = low_ff;
                  end else if (req_data.throttle_sample > high_ff && fs_ff > high_ff) begin
                     mode_in = MODE_DRIVE;
                     num_in = req_data.throttle_sample - high_ff;
                     den_in = fs_ff - high_ff;
                  end
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rem_in = '0;
            cnt_in = CNT_W'(2 * N - 1);
            if (mode_ff == MODE_NONE) begin
               qd_in = '0;
               state_in = S_DONE;
            end else begin
               qd_in = {{N{1'b0}}, num_ff} * {{N{1'b0}}, fs_ff};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = fits ? diff[N-1:0] : trial[N-1:0];
            qd_in = {qd_ff[2*N-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_go) begin
               if (!can_act) begin
                  status_in = ST_LOCKED;
                  active_in = 1'b0;
                  nulled_in = 1'b0;
               end else if (!mains_ff) begin
                  status_in = ST_OFF;
                  active_in = 1'b0;
                  nulled_in = 1'b0;
               end else if (!active_ff) begin
                  active_in = 1'b1;
                  status_in = item_ff.horn_pushed ? ST_SETUP : ST_STANDBY;
               end else if (status_ff != ST_SETUP) begin
                  if (nulled_ff || drive_res == '0) begin
                     nulled_in = 1'b1;
                     if (drive_on_ff) begin
                        status_in = moving_ff ? ST_MOVING : ST_READY;
                     end else begin
                        status_in = ST_STANDBY;
                     end
                  end else begin
                     status_in = ST_NOT_NULLED;
                  end
               end
               rsp_in.controller_status = status_in;
               rsp_in.drive_value = drive_res;
               rsp_in.brake_value = brake_res;
               rsp_in.is_active = active_in;
               rsp_in.mains_held = mains_ff;
               rsp_in.aux_on = aux_ff;
               rsp_in.reverse_selected = reverse_ff;
               rsp_in.drive_enabled = drive_on_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= DEAD_BAND_LOW_RESET;
         high_ff <= DEAD_BAND_HIGH_RESET;
         fs_ff <= FULL_SCALE_RESET;
         lock_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEAD_BAND_LOW: low_ff <= csr_wdata;
            CSR_DEAD_BAND_HIGH: high_ff <= csr_wdata;
            CSR_FULL_SCALE: fs_ff <= csr_wdata;
            CSR_LOCK_ENABLE: lock_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         mode_ff <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
         status_ff <= ST_OFF;
         active_ff <= 1'b0;
         nulled_ff <= 1'b0;
         mains_ff <= 1'b0;
         aux_ff <= 1'b0;
         reverse_ff <= 1'b0;
         drive_on_ff <= 1'b0;
         moving_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
         active_ff <= active_in;
         nulled_ff <= nulled_in;
         mains_ff <= mains_in;
         aux_ff <= aux_in;
         reverse_ff <= reverse_in;
         drive_on_ff <= drive_on_in;
         moving_ff <= moving_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      num_ff <= num_in;
      den_ff <= den_in;
      qd_ff <= qd_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

endmodule

[hw/rtl/tcs_checker.sv]
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks on the throttle controller status unit, bound to the top.
// ----------------------------------------------------------------------------
module tcs_checker
   import tcs_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_type                   req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_type                   rsp_data,
   input logic                      csr_write_en,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [SAMPLE_BITS-1:0]    csr_wdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // busy right after taking a beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // active exactly when not locked or off
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_active ==
         !(rsp_data.controller_status == ST_LOCKED ||
           rsp_data.controller_status == ST_OFF)))
      else $error("active flag disagrees with status");

   // drive and brake never both nonzero
   a_one_demand: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.drive_value == '0 || rsp_data.brake_value == '0))
      else $error("drive and brake both set");

   // mains off gives no demand and an inactive status
   a_mains_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.mains_held |->
         rsp_data.drive_value == '0 && rsp_data.brake_value == '0 &&
         (rsp_data.controller_status == ST_LOCKED ||
          rsp_data.controller_status == ST_OFF))
      else $error("demand or activity with mains off");

endmodule

bind throttle_controller_status_unit tcs_checker u_tcs_checker (.*);

[sim/throttle_controller_status_unit_tb.sv]
// ----------------------------------------------------------------------------
// throttle_controller_status_unit_tb
// Self-checking testbench for the throttle controller status unit. Directed
// power, nulling, setup and lock sequences are followed by random switch and
// throttle sessions over several dead band settings. A local model predicts
// every result, and a checker compares each result beat field by field while
// both channels idle and stall at random outside the steady phase.
// ----------------------------------------------------------------------------
module throttle_controller_status_unit_tb;
   import tcs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 125;
   localparam int REQ_BITS = $bits(req_type);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [SAMPLE_BITS-1:0]    csr_wdata = '0;

   // model copy of registers and state
   logic [SAMPLE_BITS-1:0] band_low_q = DEAD_BAND_LOW_RESET;
   logic [SAMPLE_BITS-1:0] band_high_q = DEAD_BAND_HIGH_RESET;
   logic [SAMPLE_BITS-1:0] full_scale_q = FULL_SCALE_RESET;
   logic                   lock_q = 1'b0;
   logic [2:0]             status_q = ST_OFF;
   logic                   active_q = 1'b0;
   logic                   nulled_q = 1'b0;
   logic                   mains_q = 1'b0;
   logic                   aux_q = 1'b0;
   logic                   reverse_q = 1'b0;
   logic                   drive_on_q = 1'b0;
   logic                   moving_q = 1'b0;

   rsp_type pending_status[$];
   int      error_count = 0;
   logic    steady_mode = 1'b0;
   int      session_left = 0;
   logic    session_noise = 1'b0;

   throttle_controller_status_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [SAMPLE_BITS-1:0] scale_demand(logic [SAMPLE_BITS-1:0] num,
                                                          logic [SAMPLE_BITS-1:0] den);
      int unsigned a;
      int unsigned q;
      if (den == '0) return '0;
      a = 32'(num);
      q = (a * full_scale_q) / den;
      if (q > full_scale_q) q = full_scale_q;
      return q[SAMPLE_BITS-1:0];
   endfunction

   function automatic rsp_type predict_status(req_type t);
      rsp_type                r;
      logic [SAMPLE_BITS-1:0] drive;
      logic [SAMPLE_BITS-1:0] brake;
      logic                   can_activate;
      drive = '0;
      brake = '0;
      if (t.status_received) moving_q = t.status_moving;
      case (t.mains_position)
         MAINS_POS_OFF: begin
            mains_q = 1'b0;
            aux_q = 1'b0;
         end
         MAINS_POS_ON: begin
            mains_q = 1'b1;
            aux_q = 1'b0;
         end
         MAINS_POS_PLUS: begin
            mains_q = 1'b1;
            aux_q = 1'b1;
         end
         default: ;
      endcase
      case (t.direction_position)
         DIR_POS_REV: begin
            reverse_q = 1'b1;
            drive_on_q = 1'b1;
         end
         DIR_POS_MIDDLE: drive_on_q = 1'b0;
         DIR_POS_FWD: begin
            reverse_q = 1'b0;
            drive_on_q = 1'b1;
         end
         default: ;
      endcase
      if (mains_q) begin
         if (t.throttle_sample > band_high_q && full_scale_q > band_high_q)
            drive = scale_demand(t.throttle_sample - band_high_q, full_scale_q - band_high_q);
         if (t.throttle_sample < band_low_q) begin
            brake = scale_demand(band_low_q - t.throttle_sample, band_low_q);
            drive = '0;
         end
      end
      if (lock_q)
         can_activate = !t.foreign_drive_seen && (t.mains_position > MAINS_POS_OFF);
      else
         can_activate = 1'b1;
      if (!can_activate) begin
         status_q = ST_LOCKED;
         active_q = 1'b0;
         nulled_q = 1'b0;
      end else if (!mains_q) begin
         status_q = ST_OFF;
         active_q = 1'b0;
         nulled_q = 1'b0;
      end else if (!active_q) begin
         active_q = 1'b1;
         status_q = t.horn_pushed ? ST_SETUP : ST_STANDBY;
      end else if (status_q != ST_SETUP) begin
         if (nulled_q || drive == '0) begin
            nulled_q = 1'b1;
            if (drive_on_q)
               status_q = moving_q ? ST_MOVING : ST_READY;
            else
               status_q = ST_STANDBY;
         end else begin
            status_q = ST_NOT_NULLED;
         end
      end
      r.controller_status = status_q;
      r.drive_value = drive;
      r.brake_value = brake;
      r.is_active = active_q;
      r.mains_held = mains_q;
      r.aux_on = aux_q;
      r.reverse_selected = reverse_q;
      r.drive_enabled = drive_on_q;
      return r;
   endfunction

   function automatic req_type make_tick(logic [1:0] mains, logic [1:0] dir,
                                         logic [SAMPLE_BITS-1:0] sample, logic horn,
                                         logic collision, logic stat_rx, logic stat_mv);
      req_type t;
      t.mains_position = mains;
      t.direction_position = dir;
      t.throttle_sample = sample;
      t.horn_pushed = horn;
      t.foreign_drive_seen = collision;
      t.status_received = stat_rx;
      t.status_moving = stat_mv;
      return t;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_throttle();
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] hi;
      lo = (band_low_q < band_high_q) ? band_low_q : band_high_q;
      hi = (band_low_q < band_high_q) ? band_high_q : band_low_q;
      case ($urandom_range(5))
         0, 1: return SAMPLE_BITS'($urandom_range(1023));
         2: return SAMPLE_BITS'($urandom_range(hi, lo));
         3: begin
            case ($urandom_range(6))
               0: return '0;
               1: return '1;
               2: return band_low_q;
               3: return band_high_q;
               4: return full_scale_q;
               5: return band_low_q - 1'b1;
               default: return band_high_q + 1'b1;
            endcase
         end
         4: return SAMPLE_BITS'($urandom_range(20));
         default: return SAMPLE_BITS'($urandom_range(1023, 1000));
      endcase
   endfunction

   // mostly sessions with mains held on, with short bursts of raw noise
   function automatic req_type random_tick();
      req_type    t;
      int         r;
      logic [1:0] mains;
      logic [1:0] dir;
      if (session_left == 0) begin
         session_noise = ($urandom_range(99) < 20);
         session_left = session_noise ? $urandom_range(5, 1) : $urandom_range(30, 8);
      end
      session_left--;
      if (session_noise) begin
         t = req_type'(REQ_BITS'($urandom));
         return t;
      end
      r = $urandom_range(99);
      mains = (r < 45) ? MAINS_POS_ON : (r < 85) ? MAINS_POS_PLUS :
              (r < 95) ? MAINS_POS_UNKNOWN : MAINS_POS_OFF;
      r = $urandom_range(99);
      dir = (r < 35) ? DIR_POS_FWD : (r < 60) ? DIR_POS_REV :
            (r < 85) ? DIR_POS_MIDDLE : DIR_POS_UNKNOWN;
      return make_tick(mains, dir, pick_throttle(), $urandom_range(99) < 8,
                       $urandom_range(99) < 6, 1'($urandom_range(1)),
                       1'($urandom_range(1)));
   endfunction

   task automatic send_tick(req_type item);
      int gap;
      gap = 0;
      while (!steady_mode && $urandom_range(99) < 30) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_status.push_back(predict_status(item));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [SAMPLE_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_DEAD_BAND_LOW: band_low_q = value;
         CSR_DEAD_BAND_HIGH: band_high_q = value;
         CSR_FULL_SCALE: full_scale_q = value;
         CSR_LOCK_ENABLE: lock_q = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [SAMPLE_BITS-1:0] low, logic [SAMPLE_BITS-1:0] high,
                               logic [SAMPLE_BITS-1:0] fs, logic lock);
      wait_idle();
      write_reg(CSR_DEAD_BAND_LOW, low);
      write_reg(CSR_DEAD_BAND_HIGH, high);
      write_reg(CSR_FULL_SCALE, fs);
      write_reg(CSR_LOCK_ENABLE, {{(SAMPLE_BITS-1){1'b0}}, lock});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [SAMPLE_BITS-1:0] want,
                              logic [SAMPLE_BITS-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic test_power_sequence();
      send_tick(make_tick(MAINS_POS_UNKNOWN, DIR_POS_UNKNOWN, '0, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_OFF, DIR_POS_MIDDLE, '1, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, '1, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, '1, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, 10'd500, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, 10'd541, 0, 0, 1, 1));
      send_tick(make_tick(MAINS_POS_UNKNOWN, DIR_POS_UNKNOWN, '1, 0, 1, 0, 0));
      send_tick(make_tick(MAINS_POS_PLUS, DIR_POS_MIDDLE, '0, 0, 0, 1, 0));
      send_tick(make_tick(MAINS_POS_PLUS, DIR_POS_REV, 10'd540, 0, 0, 0, 1));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_REV, 10'd479, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_OFF, DIR_POS_FWD, 10'd480, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, '1, 1, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, '1, 0, 0, 1, 1));
      send_tick(make_tick(MAINS_POS_PLUS, DIR_POS_MIDDLE, '0, 1, 1, 0, 0));
      send_tick(make_tick(MAINS_POS_OFF, DIR_POS_UNKNOWN, 10'd600, 0, 0, 0, 0));
   endtask

   task automatic test_lock_enable();
      apply_config(DEAD_BAND_LOW_RESET, DEAD_BAND_HIGH_RESET, FULL_SCALE_RESET, 1'b1);
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, 10'd500, 0, 1, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, 10'd500, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_ON, DIR_POS_FWD, 10'd500, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_UNKNOWN, DIR_POS_FWD, 10'd500, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_PLUS, DIR_POS_REV, '1, 1, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_OFF, DIR_POS_REV, '0, 0, 0, 0, 0));
      send_tick(make_tick(MAINS_POS_PLUS, DIR_POS_MIDDLE, '1, 1, 1, 1, 1));
   endtask

   task automatic test_random_ticks();
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: apply_config(DEAD_BAND_LOW_RESET, DEAD_BAND_HIGH_RESET, FULL_SCALE_RESET, 1'b0);
            1: apply_config(DEAD_BAND_LOW_RESET, DEAD_BAND_HIGH_RESET, FULL_SCALE_RESET, 1'b1);
            2: apply_config('0, '0, '1, 1'b0);
            3: apply_config('1, '1, '1, 1'b1);
            4: apply_config(10'd10, 10'd5, '1, 1'b0);
            5: apply_config(10'd100, 10'd50, 10'd1, 1'b0);
            6: apply_config(10'd300, 10'd600, 10'd700, 1'b1);
            7: apply_config(SAMPLE_BITS'($urandom_range(1023)),
                            SAMPLE_BITS'($urandom_range(1023)),
                            SAMPLE_BITS'($urandom_range(1023, 1)),
                            1'($urandom_range(1)));
            default: apply_config(DEAD_BAND_LOW_RESET, DEAD_BAND_HIGH_RESET,
                                  FULL_SCALE_RESET, 1'b0);
         endcase
         steady_mode = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) wait_idle();
            send_tick(random_tick());
         end
         steady_mode = 1'b0;
      end
   endtask

   // result checker and result side stall
   always @(posedge clock) begin
      rsp_type wanted;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_status.size() == 0) begin
            error_count++;
            $display("%0t unexpected result beat: expected none actual %h", $time, rsp_data);
         end else begin
            wanted = pending_status.pop_front();
            check_field("controller_status", SAMPLE_BITS'(wanted.controller_status),
                        SAMPLE_BITS'(rsp_data.controller_status));
            check_field("drive_value", wanted.drive_value, rsp_data.drive_value);
            check_field("brake_value", wanted.brake_value, rsp_data.brake_value);
            check_field("is_active", SAMPLE_BITS'(wanted.is_active),
                        SAMPLE_BITS'(rsp_data.is_active));
            check_field("mains_held", SAMPLE_BITS'(wanted.mains_held),
                        SAMPLE_BITS'(rsp_data.mains_held));
            check_field("aux_on", SAMPLE_BITS'(wanted.aux_on),
                        SAMPLE_BITS'(rsp_data.aux_on));
            check_field("reverse_selected", SAMPLE_BITS'(wanted.reverse_selected),
                        SAMPLE_BITS'(rsp_data.reverse_selected));
            check_field("drive_enabled", SAMPLE_BITS'(wanted.drive_enabled),
                        SAMPLE_BITS'(rsp_data.drive_enabled));
         end
      end
      rsp_stall <= !steady_mode && ($urandom_range(99) < 30);
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_power_sequence();
      test_lock_enable();
      test_random_ticks();
      wait_idle();
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0) begin
         $display("status: pass");
      end else begin
         if (pending_status.size() != 0)
            $display("%0t results missing: expected %0d more actual 0",
                     $time, pending_status.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

[throttle_controller_status_unit.f]
hw/rtl/tcs_pkg.sv
hw/rtl/throttle_controller_status_unit.sv
hw/rtl/tcs_checker.sv
sim/throttle_controller_status_unit_tb.sv
